// ----- rtl/arq_rw_pkg.sv -----
// ----------------------------------------------------------------------------
// arq_rw_pkg
// Shared types and constants for the ARQ receiver window block.
// ----------------------------------------------------------------------------
package arq_rw_pkg;

    localparam int SEQ_BITS  = 8;
    localparam int SEQ_SPAN  = 1 << SEQ_BITS;
    localparam int CNT_BITS  = SEQ_BITS + 1;
    localparam int PORT_SEQ_BITS = 8;
    localparam int PORT_CNT_BITS = 9;

    typedef logic [SEQ_BITS-1:0] seq_t;
    typedef logic [CNT_BITS-1:0] cnt_t;

    typedef enum logic [1:0] {
        MODE_STOP_WAIT  = 2'd0,
        MODE_GO_BACK_N  = 2'd1,
        MODE_SEL_REPEAT = 2'd2,
        MODE_UNUSED     = 2'd3
    } flow_mode_t;

    typedef struct packed {
        logic accept;     // capture the frame and start it
        logic walk_step;  // clear one present bit and advance
        logic load_out;   // move the finished result into the output register
    } arq_rw_cmd_t;

    typedef struct packed {
        logic walk_needed; // frame at the input is a good selective-repeat frame
        logic walk_done;   // no present bit at the expected number, or the count has reached SEQ_SPAN
        logic out_free;    // output register can take a result this cycle
    } arq_rw_status_t;

endpackage

// ----- rtl/arq_rw_ctrl.sv -----
// ----------------------------------------------------------------------------
// arq_rw_ctrl
// Sequencer: accept a frame, walk the presence map, hand off the result.
// ----------------------------------------------------------------------------
module arq_rw_ctrl
    import arq_rw_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           frame_valid,
    output logic           frame_ready,
    input  arq_rw_status_t status,
    output arq_rw_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        frame_ready   = 1'b0;
        cmd.accept    = 1'b0;
        cmd.walk_step = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                frame_ready = 1'b1;
                if (frame_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.walk_needed ? ST_WALK : ST_EMIT;
                end
            end
            ST_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                // hold until the previous result has been taken
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/arq_rw_datapath.sv -----
// ----------------------------------------------------------------------------
// arq_rw_datapath
// Mode register, expected numbers, presence map, working result and
// output register.
// ----------------------------------------------------------------------------
module arq_rw_datapath
    import arq_rw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_wr_data,
    input  logic [PORT_SEQ_BITS-1:0] frame_seq,
    input  logic                     frame_ok,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic                     ack_valid,
    output logic                     ack_positive,
    output logic [PORT_SEQ_BITS-1:0] ack_seq,
    output logic [PORT_SEQ_BITS-1:0] deliver_first,
    output logic [PORT_CNT_BITS-1:0] deliver_count,
    input  arq_rw_cmd_t              cmd,
    output arq_rw_status_t           status
);

    flow_mode_t          mode_reg;
    seq_t                gbn_exp_reg;
    seq_t                gbn_exp_next;
    seq_t                sr_exp_reg;
    seq_t                sr_exp_next;
    logic [SEQ_SPAN-1:0] present_reg;
    logic [SEQ_SPAN-1:0] present_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    // working result of the frame in progress
    logic                w_valid_reg;
    logic                w_pos_reg;
    seq_t                w_seq_reg;
    seq_t                w_first_reg;
    cnt_t                w_cnt_reg;
    logic                w_valid_next;
    logic                w_pos_next;
    seq_t                w_seq_next;
    seq_t                w_first_next;
    cnt_t                w_cnt_next;

    logic                o_valid_reg;
    logic                o_pos_reg;
    seq_t                o_seq_reg;
    seq_t                o_first_reg;
    cnt_t                o_cnt_reg;

    seq_t                in_seq;
    logic                good_in_order;

    assign in_seq        = seq_t'(frame_seq);
    assign good_in_order = frame_ok && (in_seq == gbn_exp_reg);

    assign status.walk_needed = (mode_reg == MODE_SEL_REPEAT) && frame_ok;
    assign status.walk_done   = !present_reg[sr_exp_reg] ||
                                (w_cnt_reg == cnt_t'(SEQ_SPAN));
    assign status.out_free    = !out_valid_reg || result_ready;

    always_comb
    begin
        gbn_exp_next = gbn_exp_reg;
        sr_exp_next  = sr_exp_reg;
        present_next = present_reg;
        w_valid_next = w_valid_reg;
        w_pos_next   = w_pos_reg;
        w_seq_next   = w_seq_reg;
        w_first_next = w_first_reg;
        w_cnt_next   = w_cnt_reg;

        if (cmd.accept)
        begin
            w_valid_next = 1'b0;
            w_pos_next   = 1'b0;
            w_seq_next   = '0;
            w_first_next = '0;
            w_cnt_next   = '0;
            case (mode_reg)
                MODE_STOP_WAIT:
                begin
                    w_valid_next = frame_ok;
                    w_pos_next   = frame_ok;
                    w_seq_next   = frame_ok ? in_seq : '0;
                end
                MODE_GO_BACK_N:
                begin
                    w_valid_next = 1'b1;
                    w_pos_next   = 1'b1;
                    if (good_in_order)
                    begin
                        w_seq_next   = in_seq;
                        w_first_next = in_seq;
                        w_cnt_next   = cnt_t'(1);
                        gbn_exp_next = gbn_exp_reg + seq_t'(1);
                    end
                    else
                    begin
                        // re-ack the last in-order number
                        w_seq_next = gbn_exp_reg - seq_t'(1);
                    end
                end
                MODE_SEL_REPEAT:
                begin
                    w_valid_next = 1'b1;
                    w_pos_next   = frame_ok;
                    w_seq_next   = in_seq;
                    w_first_next = sr_exp_reg;
                    if (frame_ok)
                    begin
                        present_next[in_seq] = 1'b1;
                    end
                end
                default:
                begin
                    w_valid_next = 1'b0;
                end
            endcase
        end

        // deliver one number of the run and clear its bit
        if (cmd.walk_step)
        begin
            present_next[sr_exp_reg] = 1'b0;
            sr_exp_next              = sr_exp_reg + seq_t'(1);
            w_cnt_next               = w_cnt_reg + cnt_t'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_STOP_WAIT;
            gbn_exp_reg   <= '0;
            sr_exp_reg    <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= flow_mode_t'(cfg_wr_data);
            end
            gbn_exp_reg   <= gbn_exp_next;
            sr_exp_reg    <= sr_exp_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_valid_reg <= w_valid_next;
        w_pos_reg   <= w_pos_next;
        w_seq_reg   <= w_seq_next;
        w_first_reg <= w_first_next;
        w_cnt_reg   <= w_cnt_next;
        if (cmd.load_out)
        begin
            o_valid_reg <= w_valid_reg;
            o_pos_reg   <= w_pos_reg;
            o_seq_reg   <= w_seq_reg;
            // nothing delivered reports a first number of zero
            o_first_reg <= (w_cnt_reg == '0) ? '0 : w_first_reg;
            o_cnt_reg   <= w_cnt_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign ack_valid     = o_valid_reg;
    assign ack_positive  = o_pos_reg;
    assign ack_seq       = PORT_SEQ_BITS'(o_seq_reg);
    assign deliver_first = PORT_SEQ_BITS'(o_first_reg);
    assign deliver_count = PORT_CNT_BITS'(o_cnt_reg);

endmodule

// ----- rtl/arq_receiver_window.sv -----
// ----------------------------------------------------------------------------
// arq_receiver_window
// Receiver side of an ARQ link: stop-and-wait, go-back-N, selective repeat.
// ----------------------------------------------------------------------------
// Each received frame (sequence number and check flag) yields exactly one
// result: the ack or nack to send and the in-order run delivered. In
// stop-and-wait, go-back-N and for a bad selective-repeat frame the idle
// state goes straight to the emit state; a good selective-repeat frame
// passes through the walk state first, where the presence map is walked
// one sequence number per cycle from the expected number. A new frame is
// taken as soon as the previous result has been loaded into the output
// register, even while that result waits for result_ready. The mode
// register (cfg_wr_data: 0 stop-and-wait, 1 go-back-N, 2 selective repeat)
// must be written with cfg_wr_en only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module arq_receiver_window
    import arq_rw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_wr_data,
    input  logic                     frame_valid,
    output logic                     frame_ready,
    input  logic [PORT_SEQ_BITS-1:0] frame_seq,
    input  logic                     frame_ok,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic                     ack_valid,
    output logic                     ack_positive,
    output logic [PORT_SEQ_BITS-1:0] ack_seq,
    output logic [PORT_SEQ_BITS-1:0] deliver_first,
    output logic [PORT_CNT_BITS-1:0] deliver_count
);

    arq_rw_cmd_t    cmd;
    arq_rw_status_t status;

    arq_rw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .status      (status),
        .cmd         (cmd)
    );

    arq_rw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .frame_seq     (frame_seq),
        .frame_ok      (frame_ok),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .ack_valid     (ack_valid),
        .ack_positive  (ack_positive),
        .ack_seq       (ack_seq),
        .deliver_first (deliver_first),
        .deliver_count (deliver_count),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
